// ===== rtl/ptvs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptvs_pkg
// Shared sizes, register indexes and derived widths of the periodic texel
// volume sampler.
// ----------------------------------------------------------------------------
package ptvs_pkg;

    localparam int MAX_RESOLUTION = 32;
    localparam int MAX_FRAMES     = 16;
    localparam int CHANNELS       = 4;
    localparam int TEXEL_DEPTH    = MAX_RESOLUTION * MAX_RESOLUTION * MAX_FRAMES;

    localparam int MIN_RESOLUTION = 4;
    localparam int MIN_FRAMES     = 2;

    localparam int ADDR_W = $clog2(TEXEL_DEPTH);
    localparam int RES_W  = $clog2(MAX_RESOLUTION + 1);
    localparam int FR_W   = $clog2(MAX_FRAMES + 1);
    localparam int RR_W   = $clog2(MAX_RESOLUTION * MAX_RESOLUTION + 1);

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = 49;
    localparam int MUL_B_W = 17;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Channel sum is at most 255 * 2^48.
    localparam int SUM_W = 56;
    // Rounded sum shifted right by 16 is the widest divider operand.
    localparam int DIV_W = SUM_W + 1 - 16;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_RESOLUTION       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES           = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_TILE_SIZE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_LOOP_PERIOD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HORIZONTAL_SCALE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VERTICAL_SCALE   = 3'd5;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

endpackage

// ===== rtl/ptvs_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptvs_if
// Valid/ready channels of the sampler: input items, result items and
// register writes.
// ----------------------------------------------------------------------------
interface ptvs_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] texel_index;
    logic [31:0] texel_bytes;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0] time_value;

    modport source (output valid, kind, texel_index, texel_bytes, pos_x, pos_y,
                    time_value, input ready);
    modport sink (input valid, kind, texel_index, texel_bytes, pos_x, pos_y,
                  time_value, output ready);
endinterface

interface ptvs_out_if;
    logic        valid;
    logic        ready;
    logic signed [24:0] disp_x;
    logic signed [24:0] disp_y;
    logic signed [24:0] disp_z;
    logic [15:0] fold;

    modport source (output valid, disp_x, disp_y, disp_z, fold, input ready);
    modport sink (input valid, disp_x, disp_y, disp_z, fold, output ready);
endinterface

interface ptvs_cfg_if;
    logic        valid;
    logic        ready;
    logic [ptvs_pkg::CFG_IDX_W-1:0] index;
    logic [ptvs_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/ptvs_div255.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptvs_div255
// Iterative division by 255 using the identity 256 = 255 + 1: every cycle
// the high part of the remainder folds into the quotient and the remainder.
// ----------------------------------------------------------------------------
module ptvs_div255 (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ptvs_pkg::DIV_W-1:0]    dividend,
    output logic                          done,
    output logic [ptvs_pkg::DIV_W-1:0]    quotient
);

    localparam int W = ptvs_pkg::DIV_W;

    logic         busy_reg, busy_next;
    logic [W-1:0] q_reg, q_next;
    logic [W-1:0] r_reg, r_next;

    // Invariant: dividend = 255 * q + r.
    assign done     = busy_reg && (r_reg < W'(255));
    assign quotient = q_reg;

    always_comb
    begin
        busy_next = busy_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        if (start)
        begin
            busy_next = 1'b1;
            q_next    = '0;
            r_next    = dividend;
        end
        else if (busy_reg)
        begin
            if (r_reg >= W'(256))
            begin
                q_next = q_reg + (r_reg >> 8);
                r_next = W'(r_reg[7:0]) + (r_reg >> 8);
            end
            else if (r_reg == W'(255))
            begin
                q_next = q_reg + W'(1);
                r_next = '0;
            end
            else
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
    end

endmodule

// ===== rtl/periodic_texel_volume_sampler_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_texel_volume_sampler_unit
// Wrapped trilinear sampler over a texel store of frames of square tiles.
// ----------------------------------------------------------------------------
// A write item stores one texel as it is accepted. A query item runs on one
// shared 49x17 multiplier under a sequencer: 61 multiplications, eight texel
// reads from the single-port store, and four divisions by 255 in an iterative
// unit. The result sits in an output register, and the block takes new items
// while it waits there.
// ----------------------------------------------------------------------------
module periodic_texel_volume_sampler_unit (
    input  logic       clk,
    input  logic       rst_n,
    ptvs_in_if.sink    in_ch,
    ptvs_out_if.source out_ch,
    ptvs_cfg_if.sink   cfg
);

    localparam int AW  = ptvs_pkg::ADDR_W;
    localparam int RW  = ptvs_pkg::RES_W;
    localparam int FW  = ptvs_pkg::FR_W;
    localparam int QW  = ptvs_pkg::DIV_W;
    localparam int MAW = ptvs_pkg::MUL_A_W;
    localparam int MBW = ptvs_pkg::MUL_B_W;
    localparam int MPW = ptvs_pkg::MUL_P_W;
    localparam int SW  = ptvs_pkg::SUM_W;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_ACC   = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_DSTRT = 3'd4;
    localparam logic [2:0] ST_DIV   = 3'd5;
    localparam logic [2:0] ST_FIN   = 3'd6;

    // Multiplication schedule.
    localparam logic [5:0] OP_X_LO  = 6'd0;
    localparam logic [5:0] OP_X_HI  = 6'd1;
    localparam logic [5:0] OP_Y_LO  = 6'd2;
    localparam logic [5:0] OP_Y_HI  = 6'd3;
    localparam logic [5:0] OP_T_LO  = 6'd4;
    localparam logic [5:0] OP_T_HI  = 6'd5;
    localparam logic [5:0] OP_PX    = 6'd6;
    localparam logic [5:0] OP_PY    = 6'd7;
    localparam logic [5:0] OP_PT    = 6'd8;
    localparam logic [5:0] OP_RR    = 6'd9;
    localparam logic [5:0] OP_FB0   = 6'd10;
    localparam logic [5:0] OP_FB1   = 6'd11;
    localparam logic [5:0] OP_YB0   = 6'd12;
    localparam logic [5:0] OP_YB1   = 6'd13;
    localparam logic [5:0] OP_WYT   = 6'd14;
    localparam logic [5:0] OP_W     = 6'd18;
    localparam logic [5:0] OP_TEX   = 6'd26;
    localparam logic [5:0] OP_TLAST = 6'd57;
    localparam logic [5:0] OP_SCL   = 6'd58;
    localparam logic [5:0] OP_SLAST = 6'd60;

    // Configuration registers.
    logic [6:0]  resolution_reg;
    logic [4:0]  frames_reg;
    logic [23:0] inv_tile_size_reg;
    logic [31:0] inv_loop_period_reg;
    logic [15:0] horizontal_scale_reg;
    logic [15:0] vertical_scale_reg;

    // Sequencer.
    logic [2:0] state_reg, state_next;
    logic [5:0] op_reg, op_next;
    logic [1:0] ch_reg, ch_next;

    // Query operands and intermediate values.
    logic [31:0]       pos_x_reg, pos_y_reg, time_reg;
    logic [39:0]       accx_reg, accy_reg, acct_reg;
    logic [RW-1:0]     xs0_reg, xs1_reg, ys0_reg, ys1_reg;
    logic [FW-1:0]     fr0_reg, fr1_reg;
    logic [15:0]       wx1_reg, wy1_reg, wt1_reg;
    logic [ptvs_pkg::RR_W-1:0] rr_reg;
    logic [AW-1:0]     frb_reg [2];
    logic [AW-1:0]     yb_reg [2];
    logic [32:0]       wyt_reg [4];
    logic [48:0]       w_reg [8];
    logic [SW-1:0]     sum_reg [ptvs_pkg::CHANNELS];
    logic [32:0]       e_reg;
    logic [MPW-1:0]    prod_reg;

    // Result register.
    logic              out_valid_reg;
    logic [24:0]       disp_reg [3];
    logic [24:0]       dx_reg, dy_reg, dz_reg;
    logic [15:0]       fold_res_reg, fold_reg;

    // Store.
    logic [31:0] mem [ptvs_pkg::TEXEL_DEPTH];
    logic [31:0] rd_data_reg;
    logic        mem_we, mem_re;
    logic [AW-1:0] mem_addr;

    // Derived values.
    logic [RW-1:0]  res;
    logic [FW-1:0]  nf;
    logic [16:0]    wx [2];
    logic [16:0]    wy [2];
    logic [16:0]    wt [2];
    logic [5:0]     k;
    logic [2:0]     tex;
    logic [5:0]     kj;
    logic [MAW-1:0] mul_a;
    logic [MBW-1:0] mul_b;
    logic [15:0]    scale_sel;
    logic [51:0]    biased;
    logic [24:0]    disp_val;
    logic [SW:0]    round_sum;
    logic [QW-1:0]  div_x;
    logic           div_start, div_done;
    logic [QW-1:0]  div_q;
    logic           accept_in, out_take;
    logic [RW:0]    xs0_inc, ys0_inc;
    logic [FW:0]    fr0_inc;

    ptvs_div255 u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_x),
        .done     (div_done),
        .quotient (div_q)
    );

    assign cfg.ready    = 1'b1;
    assign in_ch.ready  = (state_reg == ST_IDLE);
    assign accept_in    = in_ch.valid && in_ch.ready;
    assign out_take     = out_ch.valid && out_ch.ready;

    assign out_ch.valid  = out_valid_reg;
    assign out_ch.disp_x = dx_reg;
    assign out_ch.disp_y = dy_reg;
    assign out_ch.disp_z = dz_reg;
    assign out_ch.fold   = fold_reg;

    // Clamped tile size and frame count.
    always_comb
    begin
        if (int'(resolution_reg) < ptvs_pkg::MIN_RESOLUTION)
            res = RW'(ptvs_pkg::MIN_RESOLUTION);
        else if (int'(resolution_reg) > ptvs_pkg::MAX_RESOLUTION)
            res = RW'(ptvs_pkg::MAX_RESOLUTION);
        else
            res = RW'(resolution_reg);
        if (int'(frames_reg) < ptvs_pkg::MIN_FRAMES)
            nf = FW'(ptvs_pkg::MIN_FRAMES);
        else if (int'(frames_reg) > ptvs_pkg::MAX_FRAMES)
            nf = FW'(ptvs_pkg::MAX_FRAMES);
        else
            nf = FW'(frames_reg);
    end

    assign wx[1] = {1'b0, wx1_reg};
    assign wx[0] = 17'h10000 - {1'b0, wx1_reg};
    assign wy[1] = {1'b0, wy1_reg};
    assign wy[0] = 17'h10000 - {1'b0, wy1_reg};
    assign wt[1] = {1'b0, wt1_reg};
    assign wt[0] = 17'h10000 - {1'b0, wt1_reg};

    assign k   = op_reg - OP_TEX;
    assign tex = k[4:2];
    assign kj  = op_reg - OP_W;

    assign xs0_inc = {1'b0, prod_reg[40 +: RW]} + (RW+1)'(1);
    assign ys0_inc = {1'b0, prod_reg[40 +: RW]} + (RW+1)'(1);
    assign fr0_inc = {1'b0, prod_reg[40 +: FW]} + (FW+1)'(1);

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (op_reg <= OP_X_HI)
        begin
            mul_a = MAW'({{(MAW-32){pos_x_reg[31]}}, pos_x_reg});
            mul_b = op_reg[0] ? MBW'(inv_tile_size_reg[23:16])
                              : MBW'(inv_tile_size_reg[15:0]);
        end
        else if (op_reg <= OP_Y_HI)
        begin
            mul_a = MAW'({{(MAW-32){pos_y_reg[31]}}, pos_y_reg});
            mul_b = op_reg[0] ? MBW'(inv_tile_size_reg[23:16])
                              : MBW'(inv_tile_size_reg[15:0]);
        end
        else if (op_reg <= OP_T_HI)
        begin
            mul_a = MAW'(time_reg);
            mul_b = op_reg[0] ? MBW'(inv_loop_period_reg[31:16])
                              : MBW'(inv_loop_period_reg[15:0]);
        end
        else if (op_reg == OP_PX)
        begin
            mul_a = MAW'(accx_reg);
            mul_b = MBW'(res);
        end
        else if (op_reg == OP_PY)
        begin
            mul_a = MAW'(accy_reg);
            mul_b = MBW'(res);
        end
        else if (op_reg == OP_PT)
        begin
            mul_a = MAW'(acct_reg);
            mul_b = MBW'(nf);
        end
        else if (op_reg == OP_RR)
        begin
            mul_a = MAW'(res);
            mul_b = MBW'(res);
        end
        else if (op_reg == OP_FB0 || op_reg == OP_FB1)
        begin
            mul_a = MAW'(rr_reg);
            mul_b = op_reg[0] ? MBW'(fr1_reg) : MBW'(fr0_reg);
        end
        else if (op_reg == OP_YB0 || op_reg == OP_YB1)
        begin
            mul_a = op_reg[0] ? MAW'(ys1_reg) : MAW'(ys0_reg);
            mul_b = MBW'(res);
        end
        else if (op_reg < OP_W)
        begin
            // Index bit 0 picks the row weight, bit 1 the frame weight.
            mul_a = MAW'(wy[op_reg[0]]);
            mul_b = wt[op_reg[1]];
        end
        else if (op_reg < OP_TEX)
        begin
            mul_a = MAW'(wyt_reg[kj[2:1]]);
            mul_b = wx[kj[0]];
        end
        else if (op_reg <= OP_TLAST)
        begin
            mul_a = w_reg[tex];
            mul_b = MBW'(rd_data_reg[8*k[1:0] +: 8]);
        end
        else
        begin
            mul_a = MAW'(e_reg);
            mul_b = MBW'(scale_sel);
        end
    end

    assign scale_sel = (ch_reg == 2'd2) ? vertical_scale_reg : horizontal_scale_reg;

    // disp = round(((2e - 2^32) * scale) / 2^24), with a bias keeping it positive.
    assign biased = {2'b00, prod_reg[48:0], 1'b0} + (52'd1 << 48) + (52'd1 << 23)
                    - {4'b0, scale_sel, 32'b0};
    assign disp_val = {~biased[48], biased[47:24]};

    // Rounded channel sum ahead of the division by 255.
    always_comb
    begin
        if (ch_reg == 2'd3)
        begin
            round_sum = {1'b0, sum_reg[ch_reg]} + ((SW+1)'(255) << 31);
            div_x     = QW'(round_sum >> 32);
        end
        else
        begin
            round_sum = {1'b0, sum_reg[ch_reg]} + ((SW+1)'(255) << 15);
            div_x     = QW'(round_sum >> 16);
        end
    end

    assign div_start = (state_reg == ST_DSTRT);

    // Store port: writes come from idle, reads from the sequencer.
    assign mem_we   = accept_in && (in_ch.kind == ptvs_pkg::KIND_WRITE)
                      && (int'(in_ch.texel_index) < ptvs_pkg::TEXEL_DEPTH);
    assign mem_re   = (state_reg == ST_READ);
    always_comb
    begin
        if (state_reg == ST_READ)
            mem_addr = AW'({1'b0, frb_reg[tex[2]]} + {1'b0, yb_reg[tex[1]]}
                           + (AW+1)'(tex[0] ? xs1_reg : xs0_reg));
        else
            mem_addr = AW'(in_ch.texel_index);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= in_ch.texel_bytes;
        if (mem_re)
            rd_data_reg <= mem[mem_addr];
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        ch_next    = ch_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept_in && in_ch.kind == ptvs_pkg::KIND_QUERY)
                begin
                    state_next = ST_MUL;
                    op_next    = OP_X_LO;
                end
            end
            ST_MUL:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (op_reg == OP_TLAST)
                begin
                    ch_next    = 2'd0;
                    state_next = ST_DSTRT;
                end
                else if (op_reg >= OP_SCL)
                begin
                    ch_next    = ch_reg + 2'd1;
                    state_next = ST_DSTRT;
                end
                else
                begin
                    op_next = op_reg + 6'd1;
                    // A new texel starts with its read.
                    if (op_next >= OP_TEX && op_next[1:0] == OP_TEX[1:0])
                        state_next = ST_READ;
                    else
                        state_next = ST_MUL;
                end
            end
            ST_READ:
            begin
                state_next = ST_MUL;
            end
            ST_DSTRT:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (ch_reg == 2'd3)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        op_next    = OP_SCL + 6'(ch_reg);
                        state_next = ST_MUL;
                    end
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ch.ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= ST_IDLE;
            op_reg               <= '0;
            ch_reg               <= '0;
            out_valid_reg        <= 1'b0;
            resolution_reg       <= 7'd64;
            frames_reg           <= 5'd16;
            inv_tile_size_reg    <= 24'd16777;
            inv_loop_period_reg  <= 32'd1677722;
            horizontal_scale_reg <= 16'd256;
            vertical_scale_reg   <= 16'd256;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            ch_reg    <= ch_next;
            if (state_reg == ST_FIN && state_next == ST_IDLE)
                out_valid_reg <= 1'b1;
            else if (out_take)
                out_valid_reg <= 1'b0;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    ptvs_pkg::CFG_RESOLUTION:       resolution_reg <= cfg.data[6:0];
                    ptvs_pkg::CFG_FRAMES:           frames_reg <= cfg.data[4:0];
                    ptvs_pkg::CFG_INV_TILE_SIZE:    inv_tile_size_reg <= cfg.data[23:0];
                    ptvs_pkg::CFG_INV_LOOP_PERIOD:  inv_loop_period_reg <= cfg.data;
                    ptvs_pkg::CFG_HORIZONTAL_SCALE: horizontal_scale_reg <= cfg.data[15:0];
                    ptvs_pkg::CFG_VERTICAL_SCALE:   vertical_scale_reg <= cfg.data[15:0];
                    default:                        ;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            pos_x_reg <= in_ch.pos_x;
            pos_y_reg <= in_ch.pos_y;
            time_reg  <= in_ch.time_value;
        end

        if (state_reg == ST_MUL)
            prod_reg <= MPW'({{MBW{1'b0}}, mul_a} * {{MAW{1'b0}}, mul_b});

        if (state_reg == ST_ACC)
        begin
            if (op_reg == OP_X_LO)
                accx_reg <= prod_reg[39:0];
            else if (op_reg == OP_X_HI)
                accx_reg <= accx_reg + {prod_reg[23:0], 16'b0};
            else if (op_reg == OP_Y_LO)
                accy_reg <= prod_reg[39:0];
            else if (op_reg == OP_Y_HI)
                accy_reg <= accy_reg + {prod_reg[23:0], 16'b0};
            else if (op_reg == OP_T_LO)
                acct_reg <= prod_reg[39:0];
            else if (op_reg == OP_T_HI)
                acct_reg <= acct_reg + {prod_reg[23:0], 16'b0};
            else if (op_reg == OP_PX)
            begin
                xs0_reg <= prod_reg[40 +: RW];
                xs1_reg <= (xs0_inc >= {1'b0, res}) ? '0 : xs0_inc[RW-1:0];
                wx1_reg <= prod_reg[39:24];
            end
            else if (op_reg == OP_PY)
            begin
                ys0_reg <= prod_reg[40 +: RW];
                ys1_reg <= (ys0_inc >= {1'b0, res}) ? '0 : ys0_inc[RW-1:0];
                wy1_reg <= prod_reg[39:24];
            end
            else if (op_reg == OP_PT)
            begin
                fr0_reg <= prod_reg[40 +: FW];
                fr1_reg <= (fr0_inc >= {1'b0, nf}) ? '0 : fr0_inc[FW-1:0];
                wt1_reg <= prod_reg[39:24];
            end
            else if (op_reg == OP_RR)
                rr_reg <= prod_reg[ptvs_pkg::RR_W-1:0];
            else if (op_reg == OP_FB0 || op_reg == OP_FB1)
                frb_reg[op_reg[0]] <= prod_reg[AW-1:0];
            else if (op_reg == OP_YB0 || op_reg == OP_YB1)
                yb_reg[op_reg[0]] <= prod_reg[AW-1:0];
            else if (op_reg < OP_W)
                wyt_reg[op_reg[1:0]] <= prod_reg[32:0];
            else if (op_reg < OP_TEX)
                w_reg[kj[2:0]] <= prod_reg[48:0];
            else if (op_reg <= OP_TLAST)
            begin
                if (tex == 3'd0)
                    sum_reg[k[1:0]] <= prod_reg[SW-1:0];
                else
                    sum_reg[k[1:0]] <= sum_reg[k[1:0]] + prod_reg[SW-1:0];
            end
            else
                disp_reg[ch_reg] <= disp_val;
        end

        if (state_reg == ST_DIV && div_done)
        begin
            e_reg <= div_q[32:0];
            if (ch_reg == 2'd3)
                fold_res_reg <= (div_q > QW'(16'hFFFF)) ? 16'hFFFF : div_q[15:0];
        end

        if (state_reg == ST_FIN && state_next == ST_IDLE)
        begin
            dx_reg   <= disp_reg[0];
            dy_reg   <= disp_reg[1];
            dz_reg   <= disp_reg[2];
            fold_reg <= fold_res_reg;
        end
    end

endmodule
